// ===== sv/tpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared types, constants and helpers of the table top point filter.
// ----------------------------------------------------------------------------
package tpf_pkg;

  localparam int unsigned MIN_POINTS = 20;
  localparam int unsigned MAX_POINTS = 1048576;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned SUM_W      = 37;
  localparam int unsigned MAG_W      = SUM_W - 1;
  localparam int unsigned QUOT_W     = 16;
  localparam int unsigned STEP_W     = $clog2(QUOT_W);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned CNT_FIELD_MAX = (1 << CNT_W) - 1;
  localparam int unsigned CNT_LIMIT     =
    (MAX_POINTS < CNT_FIELD_MAX) ? MAX_POINTS : CNT_FIELD_MAX;

  // Register reset values
  localparam logic [23:0]        RST_REF_COLOR  = 24'h000000;
  localparam logic [9:0]         RST_COLOR_TOL  = 10'd765;
  localparam logic signed [15:0] RST_HEIGHT_REF = 16'sd0;
  localparam logic [14:0]        RST_HEIGHT_TOL = 15'd0;
  localparam logic signed [15:0] RST_BOX_LOW    = 16'sh8000;
  localparam logic signed [15:0] RST_BOX_HIGH   = 16'sh7FFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_COLOR  = 3'd0,
    CFG_COLOR_TOL  = 3'd1,
    CFG_HEIGHT_REF = 3'd2,
    CFG_HEIGHT_TOL = 3'd3,
    CFG_BOX_X_LOW  = 3'd4,
    CFG_BOX_X_HIGH = 3'd5,
    CFG_BOX_Y_LOW  = 3'd6,
    CFG_BOX_Y_HIGH = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_CHECK,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DIV_Z,
    ST_PUBLISH
  } state_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic                      frame_end;
  } point_t;

  typedef struct packed {
    logic                      table_found;
    logic [CNT_W-1:0]          kept_count;
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
    logic signed [COORD_W-1:0] centroid_z;
  } result_t;

  typedef struct packed {
    logic  accept;
    logic  div_start;
    axis_e start_axis;
    logic  div_latch;
    axis_e latch_axis;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic found;
    logic div_done;
    logic out_valid;
  } status_t;

  function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== sv/tpf_div.sv =====
// ----------------------------------------------------------------------------
// tpf_div
// Restoring divider: signed sum over unsigned count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tpf_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [tpf_pkg::SUM_W-1:0]    dividend_i,
  input  logic [tpf_pkg::CNT_W-1:0]           divisor_i,  // hold stable while busy
  output logic                                done_o,
  output logic signed [tpf_pkg::QUOT_W-1:0]   quot_o
);

  logic [tpf_pkg::SUM_W-1:0]  mag;
  logic [tpf_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic [tpf_pkg::QUOT_W-1:0] lo_q, lo_d;
  logic [tpf_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic                       neg_q, neg_d;
  logic [tpf_pkg::CNT_W:0]    trial;
  logic [tpf_pkg::CNT_W:0]    diff;
  logic                       fits;

  assign mag   = dividend_i[tpf_pkg::SUM_W-1] ? (-dividend_i) : dividend_i;
  assign trial = {rem_q, lo_q[tpf_pkg::QUOT_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  // The quotient magnitude stays below 2^QUOT_W, so the upper dividend bits
  // start out below the divisor and only QUOT_W steps are needed.
  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    if (start_i) begin
      rem_d  = tpf_pkg::CNT_W'(mag[tpf_pkg::MAG_W-1:tpf_pkg::QUOT_W]);
      lo_d   = mag[tpf_pkg::QUOT_W-1:0];
      cnt_d  = tpf_pkg::STEP_W'(tpf_pkg::QUOT_W - 1);
      busy_d = 1'b1;
      neg_d  = dividend_i[tpf_pkg::SUM_W-1];
    end else if (busy_q) begin
      rem_d = fits ? diff[tpf_pkg::CNT_W-1:0] : trial[tpf_pkg::CNT_W-1:0];
      lo_d  = {lo_q[tpf_pkg::QUOT_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? $signed(-lo_q) : $signed(lo_q);

endmodule

// ===== sv/tpf_dp.sv =====
// ----------------------------------------------------------------------------
// tpf_dp
// Datapath: configuration registers, point test, accumulators, divider and
// result register.
// ----------------------------------------------------------------------------
module tpf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tpf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  tpf_pkg::point_t                   in_data_i,
  input  logic                              out_ready_i,
  input  tpf_pkg::cmd_t                     cmd_i,
  output tpf_pkg::status_t                  status_o,
  output logic                              out_valid_o,
  output tpf_pkg::result_t                  out_data_o
);

  logic [23:0]        ref_color_q;
  logic [9:0]         color_tol_q;
  logic signed [15:0] height_ref_q;
  logic [14:0]        height_tol_q;
  logic signed [15:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q;

  logic [tpf_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [tpf_pkg::SUM_W-1:0]  sum_x_q, sum_x_d;
  logic signed [tpf_pkg::SUM_W-1:0]  sum_y_q, sum_y_d;
  logic signed [tpf_pkg::SUM_W-1:0]  sum_z_q, sum_z_d;
  logic signed [tpf_pkg::COORD_W-1:0] cx_q, cy_q, cz_q;
  tpf_pkg::result_t                  out_q, out_d;
  logic                              out_valid_q, out_valid_d;

  logic signed [16:0]                dz;
  logic [16:0]                       dz_neg;
  logic [15:0]                       dz_abs;
  logic [9:0]                        rgb_dist;
  logic                              keep;
  logic                              room;
  logic                              found;
  logic signed [tpf_pkg::SUM_W-1:0]  div_dividend;
  logic                              div_done;
  logic signed [tpf_pkg::QUOT_W-1:0] div_quot;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_color_q  <= tpf_pkg::RST_REF_COLOR;
      color_tol_q  <= tpf_pkg::RST_COLOR_TOL;
      height_ref_q <= tpf_pkg::RST_HEIGHT_REF;
      height_tol_q <= tpf_pkg::RST_HEIGHT_TOL;
      x_lo_q       <= tpf_pkg::RST_BOX_LOW;
      x_hi_q       <= tpf_pkg::RST_BOX_HIGH;
      y_lo_q       <= tpf_pkg::RST_BOX_LOW;
      y_hi_q       <= tpf_pkg::RST_BOX_HIGH;
    end else if (cfg_we_i) begin
      unique case (tpf_pkg::cfg_idx_e'(cfg_idx_i))
        tpf_pkg::CFG_REF_COLOR:  ref_color_q  <= cfg_wdata_i[23:0];
        tpf_pkg::CFG_COLOR_TOL:  color_tol_q  <= cfg_wdata_i[9:0];
        tpf_pkg::CFG_HEIGHT_REF: height_ref_q <= $signed(cfg_wdata_i[15:0]);
        tpf_pkg::CFG_HEIGHT_TOL: height_tol_q <= cfg_wdata_i[14:0];
        tpf_pkg::CFG_BOX_X_LOW:  x_lo_q       <= $signed(cfg_wdata_i[15:0]);
        tpf_pkg::CFG_BOX_X_HIGH: x_hi_q       <= $signed(cfg_wdata_i[15:0]);
        tpf_pkg::CFG_BOX_Y_LOW:  y_lo_q       <= $signed(cfg_wdata_i[15:0]);
        tpf_pkg::CFG_BOX_Y_HIGH: y_hi_q       <= $signed(cfg_wdata_i[15:0]);
        default: ;
      endcase
    end
  end

  // Point test
  assign dz     = {in_data_i.point_z[15], in_data_i.point_z}
                - {height_ref_q[15], height_ref_q};
  assign dz_neg = -dz;
  assign dz_abs = dz[16] ? dz_neg[15:0] : dz[15:0];

  assign rgb_dist = 10'(tpf_pkg::abs_diff8(in_data_i.red,   ref_color_q[23:16]))
                  + 10'(tpf_pkg::abs_diff8(in_data_i.green, ref_color_q[15:8]))
                  + 10'(tpf_pkg::abs_diff8(in_data_i.blue,  ref_color_q[7:0]));

  assign keep = (dz_abs < {1'b0, height_tol_q})
             && (rgb_dist < color_tol_q)
             && (in_data_i.point_x > x_lo_q) && (in_data_i.point_x < x_hi_q)
             && (in_data_i.point_y > y_lo_q) && (in_data_i.point_y < y_hi_q);

  assign room  = cnt_q < tpf_pkg::CNT_W'(tpf_pkg::CNT_LIMIT);
  assign found = cnt_q >= tpf_pkg::CNT_W'(tpf_pkg::MIN_POINTS);

  // Accumulators: advance on a kept point while below the count limit, clear once the result is loaded
  always_comb begin
    cnt_d   = cnt_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    sum_z_d = sum_z_q;
    if (cmd_i.load_out) begin
      cnt_d   = '0;
      sum_x_d = '0;
      sum_y_d = '0;
      sum_z_d = '0;
    end else if (cmd_i.accept && keep && room) begin
      cnt_d   = cnt_q + 1'b1;
      sum_x_d = sum_x_q + tpf_pkg::SUM_W'(in_data_i.point_x);
      sum_y_d = sum_y_q + tpf_pkg::SUM_W'(in_data_i.point_y);
      sum_z_d = sum_z_q + tpf_pkg::SUM_W'(in_data_i.point_z);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      sum_z_q <= sum_z_d;
    end
  end

  // Shared divider, one axis at a time
  always_comb begin
    unique case (cmd_i.start_axis)
      tpf_pkg::AXIS_X: div_dividend = sum_x_q;
      tpf_pkg::AXIS_Y: div_dividend = sum_y_q;
      default:         div_dividend = sum_z_q;
    endcase
  end

  tpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_latch) begin
      unique case (cmd_i.latch_axis)
        tpf_pkg::AXIS_X: cx_q <= div_quot;
        tpf_pkg::AXIS_Y: cy_q <= div_quot;
        default:         cz_q <= div_quot;
      endcase
    end
  end

  // Result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d       = 1'b1;
      out_d.table_found = found;
      out_d.kept_count  = cnt_q;
      out_d.centroid_x  = found ? cx_q : '0;
      out_d.centroid_y  = found ? cy_q : '0;
      out_d.centroid_z  = found ? cz_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign status_o.frame_end = in_data_i.frame_end;
  assign status_o.found     = found;
  assign status_o.div_done  = div_done;
  assign status_o.out_valid = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/tpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpf_ctrl
// Controller: point intake, centroid division sequence and result handoff.
// ----------------------------------------------------------------------------
module tpf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  input  tpf_pkg::status_t  status_i,
  output logic              in_ready_o,
  output tpf_pkg::cmd_t     cmd_o
);

  tpf_pkg::state_e state_q, state_d;
  logic            accept;
  logic            slot_free;

  assign accept    = in_valid_i && (state_q == tpf_pkg::ST_ACCUM);
  assign slot_free = !status_i.out_valid || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpf_pkg::ST_ACCUM: begin
        if (accept && status_i.frame_end) state_d = tpf_pkg::ST_CHECK;
      end
      tpf_pkg::ST_CHECK: begin
        state_d = status_i.found ? tpf_pkg::ST_DIV_X : tpf_pkg::ST_PUBLISH;
      end
      tpf_pkg::ST_DIV_X: begin
        if (status_i.div_done) state_d = tpf_pkg::ST_DIV_Y;
      end
      tpf_pkg::ST_DIV_Y: begin
        if (status_i.div_done) state_d = tpf_pkg::ST_DIV_Z;
      end
      tpf_pkg::ST_DIV_Z: begin
        if (status_i.div_done) state_d = tpf_pkg::ST_PUBLISH;
      end
      tpf_pkg::ST_PUBLISH: begin
        if (slot_free) state_d = tpf_pkg::ST_ACCUM;
      end
      default: state_d = tpf_pkg::ST_ACCUM;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o.accept     = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.start_axis = tpf_pkg::AXIS_X;
    cmd_o.div_latch  = 1'b0;
    cmd_o.latch_axis = tpf_pkg::AXIS_X;
    cmd_o.load_out   = 1'b0;
    unique case (state_q)
      tpf_pkg::ST_ACCUM: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = accept;
      end
      tpf_pkg::ST_CHECK: begin
        cmd_o.div_start  = status_i.found;
        cmd_o.start_axis = tpf_pkg::AXIS_X;
      end
      tpf_pkg::ST_DIV_X: begin
        cmd_o.div_latch  = status_i.div_done;
        cmd_o.latch_axis = tpf_pkg::AXIS_X;
        cmd_o.div_start  = status_i.div_done;
        cmd_o.start_axis = tpf_pkg::AXIS_Y;
      end
      tpf_pkg::ST_DIV_Y: begin
        cmd_o.div_latch  = status_i.div_done;
        cmd_o.latch_axis = tpf_pkg::AXIS_Y;
        cmd_o.div_start  = status_i.div_done;
        cmd_o.start_axis = tpf_pkg::AXIS_Z;
      end
      tpf_pkg::ST_DIV_Z: begin
        cmd_o.div_latch  = status_i.div_done;
        cmd_o.latch_axis = tpf_pkg::AXIS_Z;
        cmd_o.start_axis = tpf_pkg::AXIS_Z;
      end
      tpf_pkg::ST_PUBLISH: begin
        cmd_o.load_out = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpf_pkg::ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/table_top_point_filter.sv =====
// ----------------------------------------------------------------------------
// table_top_point_filter
// Keeps colored 3D points near a reference height and color inside a box,
// counts and sums them, and reports the centroid at each frame end.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   -------   ------------------------   --------------------------------
//   in        in_valid_i / in_ready_o    in_data_i   (tpf_pkg::point_t)
//   out       out_valid_o / out_ready_i  out_data_o  (tpf_pkg::result_t)
//   cfg       cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// An ordinary point is tested and accumulated in the cycle of its transfer.
// A frame-end transfer holds intake through a check state, three divides on
// the shared restoring divider (x, y, z) and a publish state; with too few
// points kept only check and publish run. Publish waits for a free output
// register, so a result not yet taken stalls intake at the next frame end.
// Reset clears the accumulators, the controller and the output valid, and
// loads the default configuration.
// ----------------------------------------------------------------------------
module table_top_point_filter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tpf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tpf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  tpf_pkg::point_t                  in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output tpf_pkg::result_t                 out_data_o
);

  tpf_pkg::cmd_t    cmd;
  tpf_pkg::status_t status;

  // Sequence intake, division and result handoff
  tpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  // Hold configuration, test points, accumulate, divide and register results
  tpf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // A frame-end transfer must stop intake until its result is built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.frame_end) |=> !in_ready_o)
    else $error("intake not paused after frame end");

  // A reported table carries at least the minimum count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.table_found)
      |-> (out_data_o.kept_count >= tpf_pkg::CNT_W'(tpf_pkg::MIN_POINTS)))
    else $error("table found with too few points");

  // No table means a zero centroid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.table_found)
      |-> (out_data_o.centroid_x == '0 && out_data_o.centroid_y == '0
           && out_data_o.centroid_z == '0))
    else $error("nonzero centroid without table");

  // Division and result loading never overlap with point transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_start || cmd.load_out) |-> !in_ready_o)
    else $error("command issued while taking points");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the table top point filter. Streams frames of
// colored points under several filter settings and idling patterns, predicts
// the frame-end report of every frame and compares each report field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  // A frame end runs a check state and three divides before its publish;
  // wait a little longer before touching the registers or finishing.
  localparam int DRAIN_CYCLES   = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_MAX     = 10;

  typedef enum int {
    SET_TYPICAL,
    SET_WIDE,
    SET_SHUT,
    SET_TIGHT
  } setting_e;

  // --------------------------------------------------------------------------
  // DUT connections, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                           clk_i     = 1'b0;
  logic                           rst_ni    = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [tpf_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [tpf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  tpf_pkg::point_t                in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  tpf_pkg::result_t               out_data;

  table_top_point_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the filter settings and accumulators
  // --------------------------------------------------------------------------
  logic [23:0] tgt_color      = tpf_pkg::RST_REF_COLOR;
  int          tgt_color_tol  = tpf_pkg::RST_COLOR_TOL;
  int          tgt_height     = tpf_pkg::RST_HEIGHT_REF;
  int          tgt_height_tol = tpf_pkg::RST_HEIGHT_TOL;
  int          lim_x_lo       = tpf_pkg::RST_BOX_LOW;
  int          lim_x_hi       = tpf_pkg::RST_BOX_HIGH;
  int          lim_y_lo       = tpf_pkg::RST_BOX_LOW;
  int          lim_y_hi       = tpf_pkg::RST_BOX_HIGH;

  int unsigned frame_kept  = 0;
  longint      frame_sum_x = 0;
  longint      frame_sum_y = 0;
  longint      frame_sum_z = 0;

  // Frame-end reports still owed by the DUT, oldest first
  tpf_pkg::result_t frame_reports[$];

  int send_gap_pct  = 0;
  int recv_gap_pct  = 0;
  int stall_request = 0;
  int setting_round = 0;
  int fail_count    = 0;
  int report_index  = 0;
  int quiet_cycles  = 0;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Receiver: drop ready at random, or hold it low for a requested stretch
  // counted here so the DUT backs up into its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_request > 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (int'($urandom_range(0, 99)) >= recv_gap_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles with no transfer and no register write
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Failure bookkeeping: show the first few, count the rest
  // --------------------------------------------------------------------------
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("ERROR: %s", msg);
    end
  endtask

  // --------------------------------------------------------------------------
  // Report checker: every output transfer is matched against the oldest
  // outstanding report. Values are sampled at the edge, before any update.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_reports
    tpf_pkg::result_t want;
    if (rst_ni && out_valid && out_ready) begin
      report_index <= report_index + 1;
      if (frame_reports.size() == 0) begin
        note_failure($sformatf("report %0d arrived with none outstanding: %h",
                               report_index, out_data));
      end else begin
        want = frame_reports.pop_front();
        if (out_data.table_found !== want.table_found)
          note_failure($sformatf("report %0d table_found: expected %0d, got %0d",
                                 report_index, want.table_found, out_data.table_found));
        if (out_data.kept_count !== want.kept_count)
          note_failure($sformatf("report %0d kept_count: expected %0d, got %0d",
                                 report_index, want.kept_count, out_data.kept_count));
        if (out_data.centroid_x !== want.centroid_x)
          note_failure($sformatf("report %0d centroid_x: expected %0d, got %0d",
                                 report_index, want.centroid_x, out_data.centroid_x));
        if (out_data.centroid_y !== want.centroid_y)
          note_failure($sformatf("report %0d centroid_y: expected %0d, got %0d",
                                 report_index, want.centroid_y, out_data.centroid_y));
        if (out_data.centroid_z !== want.centroid_z)
          note_failure($sformatf("report %0d centroid_z: expected %0d, got %0d",
                                 report_index, want.centroid_z, out_data.centroid_z));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: test one point, accumulate it, and owe a report on frame end
  // --------------------------------------------------------------------------
  function automatic int chan_err(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  task automatic absorb_point(input tpf_pkg::point_t pt);
    int               px, py, pz, dz, cerr;
    bit               kept;
    longint           n;
    tpf_pkg::result_t rpt;
    px = $signed(pt.point_x);
    py = $signed(pt.point_y);
    pz = $signed(pt.point_z);
    dz = pz - tgt_height;
    if (dz < 0) dz = -dz;
    cerr = chan_err(pt.red, tgt_color[23:16]) + chan_err(pt.green, tgt_color[15:8])
         + chan_err(pt.blue, tgt_color[7:0]);
    kept = (dz < tgt_height_tol) && (cerr < tgt_color_tol)
        && (px > lim_x_lo) && (px < lim_x_hi)
        && (py > lim_y_lo) && (py < lim_y_hi);
    // Saturated count: further matches are neither counted nor summed
    if (kept && frame_kept < tpf_pkg::CNT_LIMIT) begin
      frame_kept++;
      frame_sum_x += px;
      frame_sum_y += py;
      frame_sum_z += pz;
    end
    if (pt.frame_end) begin
      rpt             = '0;
      rpt.table_found = (frame_kept >= tpf_pkg::MIN_POINTS);
      rpt.kept_count  = tpf_pkg::CNT_W'(frame_kept);
      // Too few points: centroid stays zero; otherwise truncate toward zero
      if (rpt.table_found) begin
        n              = frame_kept;
        rpt.centroid_x = tpf_pkg::COORD_W'(frame_sum_x / n);
        rpt.centroid_y = tpf_pkg::COORD_W'(frame_sum_y / n);
        rpt.centroid_z = tpf_pkg::COORD_W'(frame_sum_z / n);
      end
      frame_reports.insert(frame_reports.size(), rpt);
      frame_kept  = 0;
      frame_sum_x = 0;
      frame_sum_y = 0;
      frame_sum_z = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: offer one point, hold it until transfer, then predict it
  // --------------------------------------------------------------------------
  task automatic send_point(input tpf_pkg::point_t pt);
    while (int'($urandom_range(0, 99)) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    do @(posedge clk_i); while (!in_ready);
    absorb_point(pt);
  endtask

  // Drop valid, wait for every owed report, then let the divider go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (frame_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Register writes; only issued while the DUT is idle
  // --------------------------------------------------------------------------
  task automatic write_reg(input tpf_pkg::cfg_idx_e idx,
                           input logic [tpf_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      tpf_pkg::CFG_REF_COLOR:  tgt_color      = value[23:0];
      tpf_pkg::CFG_COLOR_TOL:  tgt_color_tol  = value[9:0];
      tpf_pkg::CFG_HEIGHT_REF: tgt_height     = $signed(value[15:0]);
      tpf_pkg::CFG_HEIGHT_TOL: tgt_height_tol = value[14:0];
      tpf_pkg::CFG_BOX_X_LOW:  lim_x_lo       = $signed(value[15:0]);
      tpf_pkg::CFG_BOX_X_HIGH: lim_x_hi       = $signed(value[15:0]);
      tpf_pkg::CFG_BOX_Y_LOW:  lim_y_lo       = $signed(value[15:0]);
      default:                 lim_y_hi       = $signed(value[15:0]);
    endcase
  endtask

  // Random junk above the register width must be ignored by the DUT
  function automatic logic [tpf_pkg::CFG_DATA_W-1:0] with_junk(input int value,
                                                               input int width);
    logic [tpf_pkg::CFG_DATA_W-1:0] word, mask;
    mask = '1;
    mask = mask >> (tpf_pkg::CFG_DATA_W - width);
    word = tpf_pkg::CFG_DATA_W'($urandom);
    return (word & ~mask) | (tpf_pkg::CFG_DATA_W'(value) & mask);
  endfunction

  task automatic apply_setting(input setting_e kind);
    logic [23:0] color;
    int          c_tol, h_ref, h_tol, x_lo, x_hi, y_lo, y_hi;
    // Start from a moderate window, then bend it per setting
    color = 24'($urandom);
    c_tol = $urandom_range(20, 400);
    h_ref = int'($urandom_range(0, 60000)) - 30000;
    h_tol = $urandom_range(1, 3000);
    x_lo  = int'($urandom_range(0, 40000)) - 32768;
    x_hi  = x_lo + int'($urandom_range(2, 30000));
    y_lo  = int'($urandom_range(0, 40000)) - 32768;
    y_hi  = y_lo + int'($urandom_range(2, 30000));
    case (kind)
      SET_WIDE: begin
        color = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        c_tol = 765;
        h_ref = $urandom_range(0, 1) ? 32767 : -32768;
        h_tol = 32767;
        x_lo  = -32768;
        x_hi  = 32767;
        y_lo  = -32768;
        y_hi  = 32767;
      end
      SET_SHUT: begin
        // Zero tolerance or an empty box: nothing may be kept
        case ($urandom_range(0, 2))
          0:       c_tol = 0;
          1:       h_tol = 0;
          default: x_hi  = x_lo + int'($urandom_range(0, 1)) - int'($urandom_range(0, 5));
        endcase
      end
      SET_TIGHT: begin
        c_tol = 1;
        h_tol = 1;
        x_hi  = x_lo + 2;
        y_hi  = y_lo + 2;
      end
      default: ;
    endcase
    if (x_hi > 32767) x_hi = 32767;
    if (y_hi > 32767) y_hi = 32767;
    write_reg(tpf_pkg::CFG_REF_COLOR,  with_junk(color, 24));
    write_reg(tpf_pkg::CFG_COLOR_TOL,  with_junk(c_tol, 10));
    write_reg(tpf_pkg::CFG_HEIGHT_REF, with_junk(h_ref, 16));
    write_reg(tpf_pkg::CFG_HEIGHT_TOL, with_junk(h_tol, 15));
    write_reg(tpf_pkg::CFG_BOX_X_LOW,  with_junk(x_lo, 16));
    write_reg(tpf_pkg::CFG_BOX_X_HIGH, with_junk(x_hi, 16));
    write_reg(tpf_pkg::CFG_BOX_Y_LOW,  with_junk(y_lo, 16));
    write_reg(tpf_pkg::CFG_BOX_Y_HIGH, with_junk(y_hi, 16));
  endtask

  // --------------------------------------------------------------------------
  // Point builders
  // --------------------------------------------------------------------------
  function automatic tpf_pkg::point_t point_at(input int x, input int y, input int z,
                                               input int r, input int g, input int b,
                                               input bit last);
    tpf_pkg::point_t pt;
    pt.point_x   = tpf_pkg::COORD_W'(x);
    pt.point_y   = tpf_pkg::COORD_W'(y);
    pt.point_z   = tpf_pkg::COORD_W'(z);
    pt.red       = 8'(r);
    pt.green     = 8'(g);
    pt.blue      = 8'(b);
    pt.frame_end = last;
    return pt;
  endfunction

  // Mostly inside [lo, hi], sometimes on its edges, sometimes anywhere
  function automatic int pick_coord(input int lo, input int hi);
    int v;
    if (lo < -32768) lo = -32768;
    if (hi > 32767)  hi = 32767;
    case ($urandom_range(0, 19))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = lo;
          1:       v = lo + 1;
          2:       v = hi - 1;
          default: v = hi;
        endcase
      end
      default: v = (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : int'($urandom);
    endcase
    return v;
  endfunction

  function automatic int pick_chan(input int center, input int spread);
    int v;
    if ($urandom_range(0, 14) == 0) begin
      v = $urandom_range(0, 255);
    end else begin
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0)   v = 0;
      if (v > 255) v = 255;
    end
    return v;
  endfunction

  function automatic tpf_pkg::point_t make_point(input bit last);
    int spread;
    spread = tgt_color_tol / 3;
    return point_at(pick_coord(lim_x_lo, lim_x_hi), pick_coord(lim_y_lo, lim_y_hi),
                    pick_coord(tgt_height - tgt_height_tol, tgt_height + tgt_height_tol),
                    pick_chan(tgt_color[23:16], spread), pick_chan(tgt_color[15:8], spread),
                    pick_chan(tgt_color[7:0], spread), last);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings have zero height tolerance: nothing is kept
  task automatic test_reset_defaults();
    send_point(point_at(-32768, 32767, 0, 0, 0, 0, 1'b0));
    send_point(point_at(0, 0, 0, 255, 255, 255, 1'b1));
    settle();
  endtask

  // Strict bounds: each test equal to its limit rejects; 20 points just
  // inside the extremes are kept and the centroid truncates toward zero.
  task automatic test_acceptance_bounds();
    write_reg(tpf_pkg::CFG_REF_COLOR,  24'h804020);
    write_reg(tpf_pkg::CFG_COLOR_TOL,  24'd30);
    write_reg(tpf_pkg::CFG_HEIGHT_REF, 24'd100);
    write_reg(tpf_pkg::CFG_HEIGHT_TOL, 24'd500);
    write_reg(tpf_pkg::CFG_BOX_X_LOW,  24'h008000);
    write_reg(tpf_pkg::CFG_BOX_X_HIGH, 24'h007FFF);
    write_reg(tpf_pkg::CFG_BOX_Y_LOW,  24'h008000);
    write_reg(tpf_pkg::CFG_BOX_Y_HIGH, 24'h007FFF);
    send_point(point_at(-32768, 0, 100, 'h80, 'h40, 'h20, 1'b0));
    send_point(point_at(0, 32767, 100, 'h80, 'h40, 'h20, 1'b0));
    send_point(point_at(0, 0, 100, 'h8A, 'h36, 'h2A, 1'b0));
    send_point(point_at(0, 0, 600, 'h80, 'h40, 'h20, 1'b0));
    for (int i = 0; i < 20; i++) begin
      send_point(point_at((i % 2) ? 32766 : -32767, (i % 2) ? -32767 : 32766,
                          (i % 2) ? 599 : -399, (i % 3 == 0) ? 'h80 + 29 : 'h80,
                          'h40, 'h20, i == 19));
    end
    settle();
  endtask

  // Whole frames under rotating settings; short frames miss the minimum,
  // long ones straddle it.
  task automatic test_random_frames(input int sender_pct, input int receiver_pct,
                                    input int items);
    int sent, len;
    send_gap_pct = sender_pct;
    recv_gap_pct = receiver_pct;
    sent = 0;
    while (sent < items) begin
      apply_setting(setting_e'(setting_round % 4));
      setting_round++;
      repeat (3) begin
        len = $urandom_range(0, 1) ? int'($urandom_range(1, 8)) : int'($urandom_range(20, 36));
        for (int i = 0; i < len; i++) begin
          send_point(make_point(i == len - 1));
        end
        sent += len;
      end
      settle();
    end
  endtask

  // Hold the output off for a long stretch while short frames keep coming,
  // so the result register fills and the next frame end stalls intake.
  task automatic test_output_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    apply_setting(SET_WIDE);
    stall_request = HOLD_CYCLES;
    repeat (10) begin
      for (int i = 0; i < 3; i++) begin
        send_point(make_point(i == 2));
      end
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_acceptance_bounds();
    test_random_frames(21, 72, 110);
    test_random_frames(72, 21, 110);
    test_random_frames(0, 0, 110);
    test_output_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
